// ----- rtl/core/frms_pkg.sv -----
// Shared types and constants for the frame RMS level meter.
// No dependencies; imported by every module of the block.
package frms_pkg;

    localparam int SAMPLE_W          = 16;   // width of the sample field
    localparam int RMS_W             = 16;   // width of the rms field
    localparam int USED_W            = 13;   // width of the samples_used field
    localparam int DEF_MAX_FRAME     = 4096;
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int FRAME_Q_DEPTH     = 4;    // frame totals held between front and back

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       has_sample;
        logic                       last_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [RMS_W-1:0]  rms;
        logic [USED_W-1:0] samples_used;
        logic              too_long;
    } out_item_t;

endpackage

// ----- rtl/core/frms_front.sv -----
// Front end: takes samples, squares them and sums each frame.
// Depends on frms_pkg; feeds frame totals into frms_fifo.
module frms_front
    import frms_pkg::*;
#(
    parameter int MAX_FRAME   = DEF_MAX_FRAME,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int Q_DEPTH     = FRAME_Q_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  in_item_t                          in_item,
    input  logic [$clog2(Q_DEPTH+1)-1:0]      q_level,
    output logic                              push,
    output logic [2*SAMPLE_BITS-3+$clog2(MAX_FRAME+1):0] push_sum,
    output logic [$clog2(MAX_FRAME+1)-1:0]    push_cnt,
    output logic                              push_ovf
);

    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    // open-frame bookkeeping
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;

    // stage 1: magnitude
    logic                   p1_valid_reg, p1_take_reg, p1_last_reg, p1_ovf_reg;
    logic [SAMPLE_BITS-1:0] p1_mag_reg;
    logic [CNT_W-1:0]       p1_cnt_reg;

    // stage 2: square
    logic                   p2_valid_reg, p2_take_reg, p2_last_reg, p2_ovf_reg;
    logic [SQ_W-1:0]        p2_sq_reg;
    logic [CNT_W-1:0]       p2_cnt_reg;

    logic [SUM_W-1:0]       acc_reg;

    logic                   accept;
    logic                   take;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [CNT_W-1:0]       cnt_after;
    logic                   ovf_after;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic [SUM_W-1:0]       sum_now;
    logic [QCNT_W:0]        pending;

    // Credit check: every frame end already in flight needs a queue slot.
    assign pending  = (QCNT_W+1)'(q_level)
                    + (QCNT_W+1)'(p1_valid_reg & p1_last_reg)
                    + (QCNT_W+1)'(p2_valid_reg & p2_last_reg);
    assign in_stall = pending >= (QCNT_W+1)'(Q_DEPTH);
    assign accept   = in_valid && !in_stall;

    assign raw       = SAMPLE_BITS'($unsigned(in_item.sample));
    assign mag       = raw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - raw) : raw;
    assign take      = in_item.has_sample && (cnt_reg < CNT_W'(MAX_FRAME));
    assign cnt_after = cnt_reg + CNT_W'(take);
    assign ovf_after = ovf_reg | (in_item.has_sample & ~take);

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (in_item.last_of_frame)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_after;
                ovf_next = ovf_after;
            end
        end
    end

    assign prod    = p1_mag_reg * p1_mag_reg;
    assign sum_now = acc_reg + (p2_take_reg ? SUM_W'(p2_sq_reg) : SUM_W'(0));

    assign push     = p2_valid_reg && p2_last_reg;
    assign push_sum = sum_now;
    assign push_cnt = p2_cnt_reg;
    assign push_ovf = p2_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg)
            begin
                acc_reg <= p2_last_reg ? SUM_W'(0) : sum_now;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_take_reg <= take;
            p1_last_reg <= in_item.last_of_frame;
            p1_mag_reg  <= mag;
            p1_cnt_reg  <= cnt_after;
            p1_ovf_reg  <= ovf_after;
        end
        p2_take_reg <= p1_take_reg;
        p2_last_reg <= p1_last_reg;
        p2_sq_reg   <= prod[SQ_W-1:0];
        p2_cnt_reg  <= p1_cnt_reg;
        p2_ovf_reg  <= p1_ovf_reg;
    end

endmodule

// ----- rtl/core/frms_fifo.sv -----
// Small register queue of closed-frame totals between front and back.
// Depends on frms_pkg for the default depth FRAME_Q_DEPTH.
module frms_fifo
    import frms_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FRAME_Q_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               push_data,
    input  logic                           pop,
    output logic                           head_valid,
    output logic [WIDTH-1:0]               head_data,
    output logic [$clog2(DEPTH+1)-1:0]     level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             do_pop;

    assign head_valid = level_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            level_reg <= level_reg + LVL_W'(push) - LVL_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/frms_back.sv -----
// Back end: divides each frame total by its count, then takes the integer root.
// Depends on frms_pkg; reads frame totals from frms_fifo.
module frms_back
    import frms_pkg::*;
#(
    parameter int MAX_FRAME   = DEF_MAX_FRAME,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  logic [2*SAMPLE_BITS-3+$clog2(MAX_FRAME+1):0] q_sum,
    input  logic [$clog2(MAX_FRAME+1)-1:0]    q_cnt,
    input  logic                              q_ovf,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output out_item_t                         out_item
);

    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_ROOT, ST_DONE} state_t;

    state_t            state_reg, state_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              ovf_reg, ovf_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+1:0] srem_reg, srem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic [CNT_W:0]    rem_sh, rem_sub;
    logic              div_ge;
    logic [SUM_W-1:0]  quo_shift;
    logic [ROOT_W+3:0] srem_sh, trial, srem_sub;
    logic              root_ge;
    logic [ROOT_W-1:0] root_shift;

    // restoring divide, one quotient bit a cycle
    assign rem_sh    = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = rem_sh >= {1'b0, div_reg};
    assign rem_sub   = rem_sh - {1'b0, div_reg};
    assign quo_shift = {quo_reg[SUM_W-2:0], div_ge};

    // digit-by-digit root, two radicand bits a cycle
    assign srem_sh    = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial      = {2'b00, root_reg, 2'b01};
    assign root_ge    = srem_sh >= trial;
    assign srem_sub   = srem_sh - trial;
    assign root_shift = {root_reg[ROOT_W-2:0], root_ge};

    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    quo_next   = q_sum;
                    div_next   = q_cnt;
                    ovf_next   = q_ovf;
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = quo_shift;
                rem_next = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                if (step_reg == '0)
                begin
                    rad_next   = RAD_W'(quo_shift);
                    root_next  = '0;
                    srem_next  = '0;
                    step_next  = STEP_W'(ROOT_W - 1);
                    state_next = ST_ROOT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_ROOT:
            begin
                root_next = root_shift;
                srem_next = root_ge ? srem_sub[ROOT_W+1:0] : srem_sh[ROOT_W+1:0];
                rad_next  = rad_reg << 2;
                if (step_reg == '0)
                begin
                    // empty frame reads as zero level
                    out_item_next.rms          = (div_reg == '0) ? RMS_W'(0)
                                                                 : RMS_W'(root_shift);
                    out_item_next.samples_used = USED_W'(div_reg);
                    out_item_next.too_long     = ovf_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            quo_reg       <= '0;
            div_reg       <= '0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            rad_reg       <= '0;
            root_reg      <= '0;
            srem_reg      <= '0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            quo_reg       <= quo_next;
            div_reg       <= div_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            rad_reg       <= rad_next;
            root_reg      <= root_next;
            srem_reg      <= srem_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

// ----- rtl/core/frame_rms_level_meter_top.sv -----
// Frame RMS level meter. Samples: one transaction per cycle while in_stall is low, through
// the magnitude and square stages to the accumulator. Frame result: the back end divides by
// the count in a bit-serial divider, then takes the root in a bit-serial root unit; it
// takes the next frame total from the queue only after its result has been taken.
// Up to FRAME_Q_DEPTH closed frames queue ahead of the back end before input stalls.
// rst_n is asynchronous, active low; it empties the pipeline and the queue, clears the sum.
module frame_rms_level_meter_top
    import frms_pkg::*;
#(
    parameter int MAX_FRAME   = DEF_MAX_FRAME,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int ENTRY_W = SUM_W + CNT_W + 1;
    localparam int QCNT_W = $clog2(FRAME_Q_DEPTH + 1);

    // closed-frame transaction: total, count, overflow flag
    logic               push;
    logic [SUM_W-1:0]   push_sum;
    logic [CNT_W-1:0]   push_cnt;
    logic               push_ovf;
    logic               pop;
    logic               head_valid;
    logic [ENTRY_W-1:0] head_data;
    logic [QCNT_W-1:0]  q_level;

    // Front: squares and sums one sample per cycle, holds back input
    // only when the queue has no slot for a frame end in flight.
    frms_front #(
        .MAX_FRAME   (MAX_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS),
        .Q_DEPTH     (FRAME_Q_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_level  (q_level),
        .push     (push),
        .push_sum (push_sum),
        .push_cnt (push_cnt),
        .push_ovf (push_ovf)
    );

    // Queue of frame totals so the slow back end stalls sampling only when the queue fills.
    frms_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAME_Q_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_sum, push_cnt, push_ovf}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .level      (q_level)
    );

    // Back: mean square by serial divide, then integer root; result held
    // in its own register until taken.
    frms_back #(
        .MAX_FRAME   (MAX_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_sum     (head_data[ENTRY_W-1 -: SUM_W]),
        .q_cnt     (head_data[CNT_W:1]),
        .q_ovf     (head_data[0]),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- verif/frms_level_check.sv -----
// Checker for the frame RMS level meter: watches both channels, predicts each frame level.
// Depends on frms_pkg for the transaction types and default frame length.
module frms_level_check
    import frms_pkg::*;
#(
    parameter int MAX_FRAME = DEF_MAX_FRAME
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    output int        mismatches,
    output int        pending,
    output int        levels_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // open-frame state
    logic [42:0]       energy;
    logic [USED_W-1:0] taken;
    logic              dropped;

    out_item_t awaited_levels[$];
    int        fails;
    int        n_checked;

    assign mismatches     = fails;
    assign pending        = awaited_levels.size();
    assign levels_checked = n_checked;

    // floor of the square root, built MSB first
    function automatic logic [RMS_W-1:0] floor_root(input logic [42:0] v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return RMS_W'(r);
    endfunction

    function automatic void note_fail(input string what);
        fails++;
        if (fails <= 10)
            $display("[%0t] %s", $realtime, what);
    endfunction

    function automatic void absorb(input in_item_t t);
        logic [16:0] mag;
        out_item_t   level;
        if (t.has_sample)
        begin
            if (taken < MAX_FRAME)
            begin
                mag = t.sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, t.sample})
                                           : {1'b0, t.sample};
                energy += 43'(mag) * 43'(mag);
                taken++;
            end
            else
                dropped = 1'b1;
        end
        if (t.last_of_frame)
        begin
            level.rms          = (taken == 0) ? '0 : floor_root(energy / taken);
            level.samples_used = taken;
            level.too_long     = dropped;
            awaited_levels.push_back(level);
            energy  = '0;
            taken   = '0;
            dropped = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            energy  = '0;
            taken   = '0;
            dropped = 1'b0;
            awaited_levels.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_levels.size() == 0)
                    note_fail($sformatf("unexpected level: rms=%0d used=%0d long=%0b",
                              out_item.rms, out_item.samples_used, out_item.too_long));
                else
                begin
                    want = awaited_levels.pop_front();
                    n_checked++;
                    if (out_item.rms !== want.rms
                        || out_item.samples_used !== want.samples_used
                        || out_item.too_long !== want.too_long)
                        note_fail($sformatf(
                            "level mismatch: want rms=%0d used=%0d long=%0b, got rms=%0d used=%0d long=%0b",
                            want.rms, want.samples_used, want.too_long,
                            out_item.rms, out_item.samples_used, out_item.too_long));
                end
            end
            if (in_valid && !in_stall)
                absorb(in_item);
        end
    end

    initial
    begin
        fails     = 0;
        n_checked = 0;
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the frame RMS level meter testbench: clock, reset, stimulus and verdict.
// Depends on frms_pkg, frame_rms_level_meter_top and the frms_level_check module.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frms_pkg::*;

    localparam int RANDOM_ITEMS    = 1800;
    localparam int HOLD_OFF_CYCLES = 1500;   // receiver's long hold-off
    localparam int TAIL_CYCLES     = 200;    // idle tail after the last awaited level
    localparam int CYCLE_LIMIT     = 1_000_000;

    // how loud a frame's samples are drawn
    typedef enum int unsigned {ANY_LEVEL, QUIET_LEVEL, EDGE_LEVEL, LOUD_LEVEL} level_style_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    int mismatches;
    int pending;
    int levels_checked;

    bit quiet_tx;          // sender offers back-to-back while set
    bit hold_off_armed;    // asks the receiver for its one long hold-off
    int sample_items;      // transactions carrying a sample or a frame end

    frame_rms_level_meter_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    frms_level_check #(.MAX_FRAME(DEF_MAX_FRAME)) level_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .mismatches     (mismatches),
        .pending        (pending),
        .levels_checked (levels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One input transaction. The gap before it is drawn per transaction unless the
    // sender is in a quiet stretch. Returns at the edge where the block took it, so
    // a following call with no gap keeps in_valid high without a glitch.
    task automatic send(input logic signed [SAMPLE_W-1:0] s, input logic has, input logic last);
        int unsigned gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= '{sample: s, has_sample: has, last_of_frame: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (has || last)
            sample_items++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input level_style_t style);
        logic signed [SAMPLE_W-1:0] mag;
        case (style)
            QUIET_LEVEL: return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            EDGE_LEVEL:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return 16'sh8001;
                    3:       return 16'sh0001;
                    4:       return 16'shffff;
                    default: return 16'sh0000;
                endcase
            end
            LOUD_LEVEL:
            begin
                mag = SAMPLE_W'($urandom_range(24000, 32767));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default:     return SAMPLE_W'($urandom);
        endcase
    endfunction

    // A well-formed frame with random content: mostly short, now and then a few
    // hundred samples. Closed either on its last sample or by a bare frame end,
    // with the odd ignored transaction (no sample, no frame end) mixed in.
    task automatic random_frame();
        int unsigned  len;
        int unsigned  pick;
        level_style_t style;
        bit           bare_end;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = $urandom_range(0, 12);
        else if (pick < 96)
            len = $urandom_range(13, 100);
        else
            len = $urandom_range(101, 400);
        style    = level_style_t'($urandom_range(0, 3));
        bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
        quiet_tx = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send(SAMPLE_W'($urandom), 1'b0, 1'b0);
            send(draw_sample(style), 1'b1, !bare_end && (k == len - 1));
        end
        if (bare_end)
            send(SAMPLE_W'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: stall for a drawn number of cycles before each result, with quiet
    // stretches of no stalling. Once asked, it holds off for a long count of its own
    // while the sender keeps going, so the frame queue fills and in_stall rises.
    initial
    begin : receiver
        int unsigned stall_len;
        bit          hold_done;
        bit          quiet;
        hold_done = 1'b0;
        quiet     = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                quiet = !quiet;
            if (hold_off_armed && !hold_done)
            begin
                hold_done = 1'b1;
                stall_len = HOLD_OFF_CYCLES;
            end
            else
                stall_len = quiet ? 0 : $urandom_range(0, 8);
            if (stall_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Watchdog: ends the run as a failure if the results never drain.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        bit hold_sent;
        hold_sent      = 1'b0;
        sample_items   = 0;
        quiet_tx       = 1'b0;
        hold_off_armed = 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        rst_n    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: empty frames, extremes, markers ---
        send(16'sh1234, 1'b0, 1'b1);       // bare frame end on an empty frame
        send(16'sh7fff, 1'b1, 1'b1);       // largest positive, closed on its own sample
        send(16'sh8000, 1'b1, 1'b1);       // most negative: rms of full scale
        send(16'sh0000, 1'b1, 1'b0);
        send(16'sh0001, 1'b1, 1'b0);
        send(16'shffff, 1'b1, 1'b0);
        send(16'sh8001, 1'b1, 1'b0);
        send(16'sh8000, 1'b0, 1'b0);       // ignored transaction mid-frame
        send(16'sh7fff, 1'b0, 1'b1);       // bare end: sample field not used
        send(16'sh5555, 1'b1, 1'b0);
        send(16'shaaaa, 1'b1, 1'b1);
        send(16'sh0000, 1'b0, 1'b0);
        send(16'sh8000, 1'b0, 1'b1);       // empty frame again, ignored sample field
        send(16'sh0000, 1'b1, 1'b1);       // single zero sample

        // --- random frames ---
        while (sample_items < RANDOM_ITEMS)
        begin
            if (!hold_sent && sample_items > RANDOM_ITEMS / 3)
            begin
                // burst of one-sample frames against the long hold-off
                hold_sent      = 1'b1;
                hold_off_armed = 1'b1;
                quiet_tx       = 1'b1;
                for (int k = 0; k < 16; k++)
                    send(draw_sample(ANY_LEVEL), 1'b1, 1'b1);
            end
            random_frame();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d sample/frame-end transactions and %0d frame levels,",
                 sample_items, levels_checked);
        $display("incl. empty, full-scale and mixed-level frames and a long output hold-off.");
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
